[sv/lzssd_pkg.sv]
// Package for the LZSS window decoder.
// Window geometry, reset constants and the decode command type. No dependencies.
`default_nettype none

package lzssd_pkg;

    localparam int unsigned WIN_AW = 12;
    localparam int unsigned WIN_DEPTH = 4096;
    localparam int unsigned LEN_W = 5;

    localparam logic [7:0] FILL_BYTE = 8'h20;
    localparam logic [WIN_AW-1:0] WP_RESET = 12'd4078;
    localparam logic [WIN_AW-1:0] WIN_LAST = 12'd4095;
    localparam logic [LEN_W-1:0] MATCH_MIN = 5'd3;

    typedef struct packed {
        logic              valid;
        logic              is_copy;
        logic [7:0]        lit;
        logic [WIN_AW-1:0] pos;
        logic [LEN_W-1:0]  len;
    } cmd_t;

endpackage

`default_nettype wire

[sv/lzssd_stream_if.sv]
// Valid/ready stream interfaces for compressed input and decoded output items.
// Depends on nothing.
`default_nettype none

interface lzssd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

interface lzssd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

[sv/lzss_window_decoder.sv]
// LZSS window decoder top level: flag/reference parser driving the window engine.
// Uses lzssd_pkg, lzssd_stream_if and lzssd_copy_engine.
//
// in_stream (sink) takes one compressed byte per item; out_stream (source)
// gives one decoded byte per item, last_of_run marking the final byte caused
// by an input item. Both follow valid/ready; an item moves when both are high.
// After reset the 4096-byte window is filled with spaces, one entry per cycle,
// and in_stream.ready stays low until the fill is done.
// A literal shows on out_stream in the cycle after it is taken. A reference
// of n output bytes (3 to 18) occupies the window memory for a first read,
// then moves one byte per cycle through the read/write-back loop while
// out_stream keeps taking them.
// The output register frees in the cycle its byte is taken, so items follow
// with no gap; the engine and in_stream hold whenever out_stream stalls with
// a byte pending.
// After the item marked last_byte, further input is accepted and dropped
// until reset.
`default_nettype none

module lzss_window_decoder (
    input  logic        clk,
    input  logic        rst_n,
    lzssd_in_if.sink    in_stream,
    lzssd_out_if.source out_stream
);

    typedef enum logic {PH_ITEM, PH_REF} phase_t;

    phase_t          phase_reg, phase_next;
    logic [7:0]      flags_reg, flags_next;
    logic [3:0]      flags_left_reg, flags_left_next;
    logic [7:0]      pos_low_reg, pos_low_next;
    logic            done_reg, done_next;

    lzssd_pkg::cmd_t cmd;
    logic            eng_ready;
    logic            take;

    lzssd_copy_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .ready      (eng_ready),
        .out_stream (out_stream)
    );

    assign in_stream.ready = eng_ready;
    assign take = in_stream.valid && eng_ready && !done_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        flags_next      = flags_reg;
        flags_left_next = flags_left_reg;
        pos_low_next    = pos_low_reg;
        done_next       = done_reg || (in_stream.valid && eng_ready && in_stream.last_byte);
        cmd.valid       = 1'b0;
        cmd.is_copy     = 1'b0;
        cmd.lit         = in_stream.in_byte;
        cmd.pos         = {in_stream.in_byte[7:4], pos_low_reg};
        cmd.len         = lzssd_pkg::LEN_W'(in_stream.in_byte[3:0]) + lzssd_pkg::MATCH_MIN;

        if (take)
        begin
            if (phase_reg == PH_REF)
            begin
                cmd.valid   = 1'b1;
                cmd.is_copy = 1'b1;
                phase_next  = PH_ITEM;
            end
            else if (flags_left_reg == '0)
            begin
                flags_next      = in_stream.in_byte;
                flags_left_next = 4'd8;
            end
            else
            begin
                flags_next      = {1'b0, flags_reg[7:1]};
                flags_left_next = flags_left_reg - 1'b1;
                if (flags_reg[0])
                begin
                    cmd.valid = 1'b1;
                end
                else
                begin
                    pos_low_next = in_stream.in_byte;
                    phase_next   = PH_REF;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_ITEM;
            flags_reg      <= '0;
            flags_left_reg <= '0;
            pos_low_reg    <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            flags_reg      <= flags_next;
            flags_left_reg <= flags_left_next;
            pos_low_reg    <= pos_low_next;
            done_reg       <= done_next;
        end
    end

`ifndef SYNTHESIS
    a_done_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !cmd.valid)
        else $error("command issued after end of stream");
    a_flag_count: assert property (@(posedge clk) disable iff (!rst_n)
        flags_left_reg <= 4'd8)
        else $error("flag count out of range");
    a_ref_needs_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (take && phase_reg == PH_ITEM && flags_left_reg != '0 && !flags_reg[0])
        |=> (phase_reg == PH_REF))
        else $error("clear flag did not open a reference");
`endif

endmodule

`default_nettype wire

[sv/lzssd_win_ram.sv]
// 4096 x 8 history window: one write port, one read port with registered data.
// Uses lzssd_pkg.
`default_nettype none

module lzssd_win_ram (
    input  logic                         clk,
    input  logic                         we,
    input  logic [lzssd_pkg::WIN_AW-1:0] waddr,
    input  logic [7:0]                   wdata,
    input  logic                         re,
    input  logic [lzssd_pkg::WIN_AW-1:0] raddr,
    output logic [7:0]                   rdata
);

    logic [7:0] mem [lzssd_pkg::WIN_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/lzssd_copy_engine.sv]
// Window engine: clear pass, literal store, copy with forwarding for a read that races a write, output register.
// Uses lzssd_pkg, lzssd_out_if and lzssd_win_ram.
`default_nettype none

module lzssd_copy_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  lzssd_pkg::cmd_t   cmd,
    output logic              ready,
    lzssd_out_if.source       out_stream
);

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_COPY} state_t;

    state_t                       state_reg, state_next;
    logic [lzssd_pkg::WIN_AW-1:0] clr_reg, clr_next;
    logic [lzssd_pkg::WIN_AW-1:0] wp_reg, wp_next;
    logic [lzssd_pkg::WIN_AW-1:0] rd_addr_reg, rd_addr_next;
    logic [lzssd_pkg::LEN_W-1:0]  rd_left_reg, rd_left_next;
    logic [lzssd_pkg::LEN_W-1:0]  em_left_reg, em_left_next;
    logic                         s1_valid_reg, s1_valid_next;
    logic                         fwd_reg, fwd_next;
    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   out_byte_reg, out_byte_next;
    logic                         out_last_reg, out_last_next;

    logic                         slot_free;
    logic                         emit;
    logic                         issue;
    logic [7:0]                   copy_byte;
    logic                         we;
    logic [lzssd_pkg::WIN_AW-1:0] waddr;
    logic [7:0]                   wdata;
    logic                         re;
    logic [lzssd_pkg::WIN_AW-1:0] raddr;
    logic [7:0]                   rdata;

    lzssd_win_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign slot_free = !out_valid_reg || out_stream.ready;
    assign ready = (state_reg == ST_IDLE) && slot_free;
    assign copy_byte = fwd_reg ? out_byte_reg : rdata;
    assign emit = (state_reg == ST_COPY) && s1_valid_reg && slot_free;
    assign issue = (state_reg == ST_COPY) && (rd_left_reg != '0)
                   && (!s1_valid_reg || slot_free);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        wp_next        = wp_reg;
        rd_addr_next   = rd_addr_reg;
        rd_left_next   = rd_left_reg;
        em_left_next   = em_left_reg;
        s1_valid_next  = s1_valid_reg;
        fwd_next       = fwd_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !out_stream.ready;
        we             = 1'b0;
        waddr          = wp_reg;
        wdata          = copy_byte;
        re             = 1'b0;
        raddr          = rd_addr_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = lzssd_pkg::FILL_BYTE;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == lzssd_pkg::WIN_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd.valid && ready)
                begin
                    if (cmd.is_copy)
                    begin
                        re            = 1'b1;
                        raddr         = cmd.pos;
                        rd_addr_next  = cmd.pos + 1'b1;
                        rd_left_next  = cmd.len - 1'b1;
                        em_left_next  = cmd.len;
                        s1_valid_next = 1'b1;
                        fwd_next      = 1'b0;
                        state_next    = ST_COPY;
                    end
                    else
                    begin
                        we             = 1'b1;
                        wdata          = cmd.lit;
                        wp_next        = wp_reg + 1'b1;
                        out_valid_next = 1'b1;
                        out_byte_next  = cmd.lit;
                        out_last_next  = 1'b1;
                    end
                end
            end
            ST_COPY:
            begin
                if (emit)
                begin
                    we             = 1'b1;
                    wp_next        = wp_reg + 1'b1;
                    out_valid_next = 1'b1;
                    out_byte_next  = copy_byte;
                    out_last_next  = (em_left_reg == 1'b1);
                    em_left_next   = em_left_reg - 1'b1;
                    if (em_left_reg == 1'b1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                if (issue)
                begin
                    re           = 1'b1;
                    rd_addr_next = rd_addr_reg + 1'b1;
                    rd_left_next = rd_left_reg - 1'b1;
                    // read racing the write of the same entry sees old data
                    fwd_next     = emit && (rd_addr_reg == wp_reg);
                end
                s1_valid_next = issue || (s1_valid_reg && !emit);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            wp_reg        <= lzssd_pkg::WP_RESET;
            rd_left_reg   <= '0;
            em_left_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            wp_reg        <= wp_next;
            rd_left_reg   <= rd_left_next;
            em_left_reg   <= em_left_next;
            s1_valid_reg  <= s1_valid_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= rd_addr_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_stream.valid       = out_valid_reg;
    assign out_stream.out_byte    = out_byte_reg;
    assign out_stream.last_of_run = out_last_reg;

`ifndef SYNTHESIS
    a_copy_has_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY) |-> s1_valid_reg)
        else $error("copy state without a pending read");
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!out_valid_reg && !ready))
        else $error("activity during clear pass");
    a_emit_advances_wp: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (wp_reg == $past(wp_reg) + 1'b1) && out_valid_reg)
        else $error("copy byte not written or not presented");
    a_reads_lead_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY) |-> (em_left_reg == rd_left_reg + 1'b1))
        else $error("read and emit counts out of step");
`endif

endmodule

`default_nettype wire
